// ===== hw/rtl/epsl_pkg.sv =====
// shared types, constants and code table for the error priority status led
package epsl_pkg;

   localparam int NUM_CODES  = 9;
   localparam int SEV_WEIGHT = 10;

   localparam logic [3:0] NO_CODE = 4'd9;

   typedef enum logic [1:0] {
      CMD_SET   = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic        red;
      logic        green;
      logic [10:0] half_ms;
      logic [2:0]  prio;
   } code_info_type;

   function automatic code_info_type code_info(input logic [3:0] code);
      code_info_type info;
      case (code)
         4'd0: info = '{red: 1'b1, green: 1'b1, half_ms: 11'd900,  prio: 3'd2};
         4'd1: info = '{red: 1'b1, green: 1'b1, half_ms: 11'd250,  prio: 3'd4};
         4'd2: info = '{red: 1'b1, green: 1'b0, half_ms: 11'd600,  prio: 3'd3};
         4'd3: info = '{red: 1'b1, green: 1'b0, half_ms: 11'd1200, prio: 3'd1};
         4'd4: info = '{red: 1'b1, green: 1'b0, half_ms: 11'd200,  prio: 3'd5};
         4'd5: info = '{red: 1'b1, green: 1'b0, half_ms: 11'd800,  prio: 3'd2};
         4'd6: info = '{red: 1'b0, green: 1'b1, half_ms: 11'd500,  prio: 3'd2};
         4'd7: info = '{red: 1'b0, green: 1'b1, half_ms: 11'd1500, prio: 3'd1};
         4'd8: info = '{red: 1'b1, green: 1'b0, half_ms: 11'd400,  prio: 3'd3};
         default: info = '{red: 1'b0, green: 1'b0, half_ms: 11'd0, prio: 3'd0};
      endcase
      return info;
   endfunction

endpackage

// ===== hw/rtl/epsl_if.sv =====
// request and response channel interfaces of the error priority status led
interface epsl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [3:0] code;
   logic [1:0] severity;

   modport source (output valid, output cmd, output code, output severity, input ready);
   modport sink   (input valid, input cmd, input code, input severity, output ready);
endinterface

interface epsl_rsp_if;
   logic       valid;
   logic       ready;
   logic       led_red;
   logic       led_grn;
   logic [3:0] shown_code;
   logic       event_valid;
   logic       event_active;
   logic [1:0] event_severity;

   modport source (output valid, output led_red, output led_grn, output shown_code,
                   output event_valid, output event_active, output event_severity,
                   input ready);
   modport sink   (input valid, input led_red, input led_grn, input shown_code,
                   input event_valid, input event_active, input event_severity,
                   output ready);
endinterface

// ===== hw/rtl/error_priority_status_led.sv =====
// error priority status led: per-code error table, rank select and blink timing
//
// channel   dir  fields
// req_ch    in   cmd[1:0] code[3:0] severity[1:0]
// rsp_ch    out  led_red led_grn shown_code[3:0] event_valid event_active event_severity[1:0]
//
// one request per cycle while the response side is not stalled; a request is held in
// the input register, and the table update, nine-way rank compare and blink step
// complete from there into the response register
// synchronous reset clears the table, selects no code and empties both registers
// a stalled response holds the pipe; the input register still takes one request
module error_priority_status_led (
   input logic clock,
   input logic reset,
   epsl_req_if.sink   req_ch,
   epsl_rsp_if.source rsp_ch
);

   // input register
   logic       req_valid_ff, req_valid_in;
   logic [1:0] req_cmd_ff;
   logic [3:0] req_code_ff;
   logic [1:0] req_severity_ff;

   // state
   logic [epsl_pkg::NUM_CODES-1:0] active_ff, active_in;
   logic [1:0] severity_ff [epsl_pkg::NUM_CODES];
   logic [1:0] severity_in [epsl_pkg::NUM_CODES];
   logic [3:0]  selected_ff, selected_in;
   logic        phase_ff, phase_in;
   logic [10:0] counter_ff, counter_in;

   // response register
   logic       out_valid_ff, out_valid_in;
   logic       out_red_ff, out_red_in;
   logic       out_green_ff, out_green_in;
   logic [3:0] out_code_ff;
   logic       out_ev_valid_ff, out_ev_valid_in;
   logic       out_ev_active_ff, out_ev_active_in;
   logic [1:0] out_ev_sev_ff, out_ev_sev_in;

   logic advance;
   logic fire;
   logic take;
   logic in_range;
   logic update;
   logic found;
   logic [5:0]  top_rank;
   logic [5:0]  rank;
   logic [10:0] count_next;
   epsl_pkg::code_info_type sel_info;
   epsl_pkg::code_info_type new_info;
   epsl_pkg::code_info_type loop_info;

   assign advance     = !out_valid_ff || rsp_ch.ready;
   assign fire        = req_valid_ff && advance;
   assign req_ch.ready = !req_valid_ff || advance;
   assign take        = req_ch.valid && req_ch.ready;

   assign req_valid_in = take ? 1'b1 : (fire ? 1'b0 : req_valid_ff);
   assign out_valid_in = fire ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   assign in_range = req_code_ff < 4'(epsl_pkg::NUM_CODES);
   assign sel_info = epsl_pkg::code_info(selected_ff);

   always_comb begin
      active_in        = active_ff;
      severity_in      = severity_ff;
      selected_in      = selected_ff;
      phase_in         = phase_ff;
      counter_in       = counter_ff;
      out_ev_valid_in  = 1'b0;
      out_ev_active_in = 1'b0;
      out_ev_sev_in    = 2'd0;
      update           = 1'b0;
      count_next       = counter_ff + 11'd1;
      found            = 1'b0;
      top_rank         = 6'd0;
      rank             = 6'd0;
      loop_info        = '0;
      case (epsl_pkg::cmd_type'(req_cmd_ff))
         epsl_pkg::CMD_SET: begin
            if (in_range) begin
               if (!active_ff[req_code_ff] || severity_ff[req_code_ff] != req_severity_ff) begin
                  out_ev_valid_in  = 1'b1;
                  out_ev_active_in = 1'b1;
                  out_ev_sev_in    = req_severity_ff;
               end
               active_in[req_code_ff]   = 1'b1;
               severity_in[req_code_ff] = req_severity_ff;
               update = 1'b1;
            end
         end
         epsl_pkg::CMD_CLEAR: begin
            if (in_range) begin
               if (active_ff[req_code_ff]) begin
                  out_ev_valid_in = 1'b1;
                  out_ev_sev_in   = severity_ff[req_code_ff];
               end
               active_in[req_code_ff] = 1'b0;
               update = 1'b1;
            end
         end
         epsl_pkg::CMD_TICK: begin
            if (selected_ff != epsl_pkg::NO_CODE) begin
               if (count_next >= sel_info.half_ms) begin
                  counter_in = 11'd0;
                  phase_in   = !phase_ff;
               end else begin
                  counter_in = count_next;
               end
            end
         end
         default: begin
         end
      endcase
      if (update) begin
         selected_in = epsl_pkg::NO_CODE;
         for (int i = 0; i < epsl_pkg::NUM_CODES; i++) begin
            loop_info = epsl_pkg::code_info(4'(i));
            rank = 6'(severity_in[i]) * 6'(epsl_pkg::SEV_WEIGHT) + 6'(loop_info.prio);
            if (active_in[i] && (!found || rank > top_rank)) begin
               found       = 1'b1;
               top_rank    = rank;
               selected_in = 4'(i);
            end
         end
         counter_in = 11'd0;
         phase_in   = found;
      end
   end

   assign new_info = epsl_pkg::code_info(selected_in);

   always_comb begin
      if (selected_in == epsl_pkg::NO_CODE) begin
         out_red_in   = 1'b0;
         out_green_in = 1'b1;
      end else if (phase_in) begin
         out_red_in   = new_info.red;
         out_green_in = new_info.green;
      end else begin
         out_red_in   = 1'b0;
         out_green_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         active_ff    <= '0;
         for (int i = 0; i < epsl_pkg::NUM_CODES; i++) begin
            severity_ff[i] <= 2'd0;
         end
         selected_ff  <= epsl_pkg::NO_CODE;
         phase_ff     <= 1'b0;
         counter_ff   <= 11'd0;
      end else begin
         req_valid_ff <= req_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            active_ff   <= active_in;
            severity_ff <= severity_in;
            selected_ff <= selected_in;
            phase_ff    <= phase_in;
            counter_ff  <= counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         req_cmd_ff      <= req_ch.cmd;
         req_code_ff     <= req_ch.code;
         req_severity_ff <= req_ch.severity;
      end
      if (fire) begin
         out_red_ff       <= out_red_in;
         out_green_ff     <= out_green_in;
         out_code_ff      <= selected_in;
         out_ev_valid_ff  <= out_ev_valid_in;
         out_ev_active_ff <= out_ev_active_in;
         out_ev_sev_ff    <= out_ev_sev_in;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.led_red        = out_red_ff;
   assign rsp_ch.led_grn        = out_green_ff;
   assign rsp_ch.shown_code     = out_code_ff;
   assign rsp_ch.event_valid    = out_ev_valid_ff;
   assign rsp_ch.event_active   = out_ev_active_ff;
   assign rsp_ch.event_severity = out_ev_sev_ff;

   // no selection means steady green
   a_idle_green: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.shown_code == epsl_pkg::NO_CODE
         |-> rsp_ch.led_grn && !rsp_ch.led_red)
      else $error("idle led not steady green");

   // blink counter stays below the selected half-period
   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      selected_ff != epsl_pkg::NO_CODE |-> counter_ff < sel_info.half_ms)
      else $error("blink counter out of range");

   // selected code is active, or none is selected
   a_selected_active: assert property (@(posedge clock) disable iff (reset)
      selected_ff == epsl_pkg::NO_CODE || (selected_ff < 4'(epsl_pkg::NUM_CODES)
         && active_ff[selected_ff]))
      else $error("selected code not active");

   // no selection keeps the phase dark and the counter at zero
   a_idle_state: assert property (@(posedge clock) disable iff (reset)
      selected_ff == epsl_pkg::NO_CODE |-> !phase_ff && counter_ff == 11'd0)
      else $error("idle blink state not cleared");

   // a request leaving the input register lands in the response register
   a_fire_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("request lost between stages");

endmodule

// ===== tb/status_led_checker.sv =====
// request/response checker for the error priority status led: predicts each response and compares
module status_led_checker (
   input  logic clock,
   input  logic reset,
   epsl_req_if  req_ch,
   epsl_rsp_if  rsp_ch,
   output int   mismatch_count,
   output int   outstanding
);

   typedef struct packed {
      logic       led_red;
      logic       led_grn;
      logic [3:0] shown_code;
      logic       event_valid;
      logic       event_active;
      logic [1:0] event_severity;
   } led_status_type;

   // per-code color, blink half-period and priority, code 8 leftmost
   localparam logic [epsl_pkg::NUM_CODES-1:0] RED_MASK   = 9'b100111111;
   localparam logic [epsl_pkg::NUM_CODES-1:0] GREEN_MASK = 9'b011000011;
   localparam logic [epsl_pkg::NUM_CODES-1:0][10:0] HALF_MS = {
      11'd400, 11'd1500, 11'd500, 11'd800, 11'd200, 11'd1200, 11'd600, 11'd250, 11'd900
   };
   localparam logic [epsl_pkg::NUM_CODES-1:0][2:0] PRIO = {
      3'd3, 3'd1, 3'd2, 3'd2, 3'd5, 3'd1, 3'd3, 3'd4, 3'd2
   };

   logic [epsl_pkg::NUM_CODES-1:0] code_active;
   logic [1:0]                     code_severity [epsl_pkg::NUM_CODES];
   logic [3:0]                     shown;
   logic                           phase_lit;
   logic [10:0]                    phase_count;

   led_status_type expected_status [$];

   task automatic predict_status(input logic [1:0] cmd, input logic [3:0] code,
                                 input logic [1:0] sev, output led_status_type status);
      logic update;
      int   top_rank;
      int   rank;
      status = '0;
      update = 1'b0;
      if (cmd == epsl_pkg::CMD_SET && code < epsl_pkg::NUM_CODES) begin
         if (!code_active[code] || code_severity[code] != sev) begin
            status.event_valid    = 1'b1;
            status.event_active   = 1'b1;
            status.event_severity = sev;
         end
         code_active[code]   = 1'b1;
         code_severity[code] = sev;
         update = 1'b1;
      end else if (cmd == epsl_pkg::CMD_CLEAR && code < epsl_pkg::NUM_CODES) begin
         if (code_active[code]) begin
            status.event_valid    = 1'b1;
            status.event_severity = code_severity[code];
         end
         code_active[code] = 1'b0;
         update = 1'b1;
      end else if (cmd == epsl_pkg::CMD_TICK && shown < epsl_pkg::NUM_CODES) begin
         phase_count = phase_count + 11'd1;
         if (phase_count >= HALF_MS[shown]) begin
            phase_count = '0;
            phase_lit   = !phase_lit;
         end
      end

      // highest rank wins, lowest code on a tie
      if (update) begin
         shown = epsl_pkg::NO_CODE;
         top_rank = -1;
         for (int i = 0; i < epsl_pkg::NUM_CODES; i++) begin
            rank = int'(code_severity[i]) * epsl_pkg::SEV_WEIGHT + int'(PRIO[i]);
            if (code_active[i] && rank > top_rank) begin
               top_rank = rank;
               shown = 4'(i);
            end
         end
         phase_count = '0;
         phase_lit   = (shown != epsl_pkg::NO_CODE);
      end

      status.shown_code = shown;
      if (shown >= epsl_pkg::NUM_CODES) begin
         status.led_grn = 1'b1;
      end else if (phase_lit) begin
         status.led_red = RED_MASK[shown];
         status.led_grn = GREEN_MASK[shown];
      end
   endtask

   task automatic check_field(input string field, input logic [3:0] want, input logic [3:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch_channels
      led_status_type want;
      if (reset) begin
         code_active = '0;
         for (int i = 0; i < epsl_pkg::NUM_CODES; i++) code_severity[i] = 2'd0;
         shown       = epsl_pkg::NO_CODE;
         phase_lit   = 1'b0;
         phase_count = '0;
         expected_status.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_status.size() == 0) begin
               $error("response with no request pending");
               mismatch_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("led_red", 4'(want.led_red), 4'(rsp_ch.led_red));
               check_field("led_grn", 4'(want.led_grn), 4'(rsp_ch.led_grn));
               check_field("shown_code", want.shown_code, rsp_ch.shown_code);
               check_field("event_valid", 4'(want.event_valid), 4'(rsp_ch.event_valid));
               check_field("event_active", 4'(want.event_active), 4'(rsp_ch.event_active));
               check_field("event_severity", 4'(want.event_severity),
                           4'(rsp_ch.event_severity));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_status(req_ch.cmd, req_ch.code, req_ch.severity, want);
            expected_status.push_back(want);
         end
      end
      outstanding = expected_status.size();
   end

endmodule

// ===== tb/testbench.sv =====
// top of the error priority status led testbench: clock, reset, request stimulus and verdict
module testbench;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         PHASE_ITEMS = 467;

   typedef enum {PHASE_RSP_SLOW, PHASE_REQ_SLOW, PHASE_NO_IDLE} idle_phase_type;

   logic clock = 1'b0;
   logic reset;

   idle_phase_type idle_phase = PHASE_RSP_SLOW;
   int             req_idle_pct = 22;
   int             rsp_idle_pct = 70;
   int             mismatch_count;
   int             outstanding;
   int             cycle_count = 0;

   epsl_req_if req_ch ();
   epsl_rsp_if rsp_ch ();

   error_priority_status_led dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   status_led_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   always #6 clock = ~clock;

   task automatic send_request(input logic [1:0] cmd, input logic [3:0] code,
                               input logic [1:0] severity);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.code     <= code;
      req_ch.severity <= severity;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // response side, with one long hold-off once idling stops
   initial begin : rsp_drain
      int hold_left = 0;
      bit pressure_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!pressure_done && idle_phase == PHASE_NO_IDLE) begin
            hold_left     = 150;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int pick;
      int burst;
      int sent;
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= epsl_pkg::CMD_SET;
      req_ch.code     <= 4'd0;
      req_ch.severity <= 2'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle led, ignored requests, ties, severity changes, clears
      send_request(epsl_pkg::CMD_TICK, 4'd0, 2'd0);
      send_request(epsl_pkg::CMD_SET, 4'd15, 2'd3);
      send_request(CMD_UNUSED, 4'd9, 2'd2);
      send_request(epsl_pkg::CMD_CLEAR, 4'd4, 2'd0);
      send_request(epsl_pkg::CMD_SET, 4'd5, 2'd1);
      send_request(epsl_pkg::CMD_SET, 4'd0, 2'd1);
      send_request(epsl_pkg::CMD_SET, 4'd6, 2'd1);
      send_request(epsl_pkg::CMD_SET, 4'd0, 2'd1);
      send_request(epsl_pkg::CMD_TICK, 4'd0, 2'd0);
      send_request(epsl_pkg::CMD_CLEAR, 4'd0, 2'd2);
      send_request(epsl_pkg::CMD_SET, 4'd7, 2'd3);
      send_request(epsl_pkg::CMD_SET, 4'd3, 2'd3);
      send_request(epsl_pkg::CMD_SET, 4'd4, 2'd3);
      send_request(epsl_pkg::CMD_SET, 4'd8, 2'd2);
      send_request(epsl_pkg::CMD_SET, 4'd1, 2'd0);
      send_request(epsl_pkg::CMD_SET, 4'd2, 2'd0);
      send_request(epsl_pkg::CMD_SET, 4'd4, 2'd0);
      send_request(epsl_pkg::CMD_CLEAR, 4'd9, 2'd0);
      send_request(epsl_pkg::CMD_CLEAR, 4'd12, 2'd1);
      send_request(epsl_pkg::CMD_TICK, 4'd15, 2'd3);
      send_request(epsl_pkg::CMD_CLEAR, 4'd4, 2'd2);
      send_request(epsl_pkg::CMD_CLEAR, 4'd4, 2'd0);

      for (int p = 0; p < 3; p++) begin
         idle_phase   = idle_phase_type'(p);
         req_idle_pct = (idle_phase == PHASE_REQ_SLOW) ? 70 :
                        (idle_phase == PHASE_RSP_SLOW) ? 22 : 0;
         rsp_idle_pct = (idle_phase == PHASE_RSP_SLOW) ? 70 :
                        (idle_phase == PHASE_REQ_SLOW) ? 22 : 0;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 5) begin
               send_request(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                            2'($urandom_range(0, 3)));
               sent++;
            end else if (pick < 40) begin
               send_request(epsl_pkg::CMD_SET, 4'($urandom_range(0, 8)),
                            2'($urandom_range(0, 3)));
               sent++;
            end else if (pick < 65) begin
               send_request(epsl_pkg::CMD_CLEAR, 4'($urandom_range(0, 8)),
                            2'($urandom_range(0, 3)));
               sent++;
            end else if (pick < 98) begin
               send_request(epsl_pkg::CMD_TICK, 4'($urandom_range(0, 15)),
                            2'($urandom_range(0, 3)));
               sent++;
            end else begin
               // tick runs so the shorter blink periods roll over
               burst = $urandom_range(1, 300);
               if (burst > PHASE_ITEMS - sent) begin
                  burst = PHASE_ITEMS - sent;
               end
               repeat (burst) begin
                  send_request(epsl_pkg::CMD_TICK, 4'($urandom_range(0, 15)),
                               2'($urandom_range(0, 3)));
               end
               sent = sent + burst;
            end
         end
      end
      req_ch.valid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/epsl_pkg.sv
hw/rtl/epsl_if.sv
hw/rtl/error_priority_status_led.sv
tb/status_led_checker.sv
tb/testbench.sv
